// ===== rtl/ctb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Countdown timer bank package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package ctb_pkg;

  // Fixed widths of the item fields.
  localparam int SLOT_W  = 4;
  localparam int FIELD_W = 16;
  localparam int MODE_W  = 2;

  // At most this many expiries are reported per tick.
  localparam int MAX_REPORTS = 16;
  localparam int REP_W       = 5;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  // Result kinds.
  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_ISSUE,
    ST_RD_OUT,
    ST_T_READ,
    ST_T_UPD,
    ST_T_FLUSH
  } state_t;

  typedef struct packed {
    logic capture;     // register the accepted item, restart the walk
    logic load_wr;     // write the item into its slot
    logic rd_issue;    // read the item's slot
    logic rd_push;     // present the read result
    logic walk_read;   // read the slot under the walk index
    logic walk_upd;    // update that slot and collect any expiry
    logic idx_inc;     // step the walk index
    logic flush_push;  // present the held expiry as the final result
  } cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic upd_stall;   // update must wait for the output register
    logic idx_last;    // walk index is on the last slot
    logic hold_valid;  // an expiry is held back
  } stat_t;

endpackage : ctb_pkg
`default_nettype wire

// ===== rtl/ctb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Countdown timer bank controller
// Sequences load, read and tick items over the datapath.
// ----------------------------------------------------------------------------
module ctb_ctrl (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [ctb_pkg::MODE_W-1:0]  in_mode,
  input  wire  ctb_pkg::stat_t        stat,
  output ctb_pkg::cmd_t               cmd
);
  import ctb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_mode)
            MODE_TICK: state_next = ST_T_READ;
            MODE_LOAD: state_next = ST_LOAD;
            MODE_READ: state_next = ST_RD_ISSUE;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (stat.out_free) begin
          cmd.rd_push = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_T_READ: begin
        cmd.walk_read = 1'b1;
        state_next    = ST_T_UPD;
      end
      ST_T_UPD: begin
        if (!stat.upd_stall) begin
          cmd.walk_upd = 1'b1;
          if (stat.idx_last) begin
            state_next = ST_T_FLUSH;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_T_READ;
          end
        end
      end
      ST_T_FLUSH: begin
        if (!stat.hold_valid) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush_push = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule : ctb_ctrl
`default_nettype wire

// ===== rtl/ctb_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Countdown timer bank datapath
// Slot stores, shared decrementer, expiry hold register and output register.
// ----------------------------------------------------------------------------
module ctb_dpath #(
  parameter int NUM_SLOTS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  [ctb_pkg::SLOT_W-1:0]   in_slot,
  input  wire  [ctb_pkg::FIELD_W-1:0]  in_delay,
  input  wire  [ctb_pkg::FIELD_W-1:0]  in_period,
  input  wire                          in_event,
  input  wire  ctb_pkg::cmd_t          cmd,
  output ctb_pkg::stat_t               stat,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_kind,
  output logic [ctb_pkg::SLOT_W-1:0]   out_slot,
  output logic [ctb_pkg::FIELD_W-1:0]  out_rem,
  output logic                         out_last
);
  import ctb_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Item registers.
  logic [SLOT_W-1:0]      item_slot;
  logic [COUNT_WIDTH-1:0] item_delay;
  logic [COUNT_WIDTH-1:0] item_period;
  logic                   item_event;

  // Slot stores; an entry whose valid bit is clear reads as zero.
  logic [COUNT_WIDTH-1:0] count_mem  [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] period_mem [NUM_SLOTS];
  logic                   event_mem  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   vld;

  logic [COUNT_WIDTH-1:0] rd_count;
  logic [COUNT_WIDTH-1:0] rd_period;
  logic                   rd_event;
  logic                   rd_vld;

  logic [IW-1:0]          idx;
  logic [REP_W-1:0]       rep_cnt;

  logic                   hold_valid;
  logic [SLOT_W-1:0]      hold_slot;
  logic [FIELD_W-1:0]     hold_rem;

  logic                   slot_ok;
  logic [IW-1:0]          slot_addr;
  logic [IW-1:0]          rd_addr;
  logic                   rd_en;
  logic [IW-1:0]          wr_addr;
  logic                   wr_en;
  logic [COUNT_WIDTH-1:0] wr_count;
  logic [COUNT_WIDTH-1:0] wr_period;
  logic                   wr_event;

  logic [COUNT_WIDTH-1:0] eff_count;
  logic [COUNT_WIDTH-1:0] eff_period;
  logic [COUNT_WIDTH-1:0] dec_count;
  logic                   active;
  logic                   expire;
  logic                   report;
  logic                   out_free;
  logic                   upd_push;
  logic [31:0]            count_ext;
  logic [31:0]            period_ext;

  assign slot_ok   = (32'(item_slot) < 32'(NUM_SLOTS));
  assign slot_addr = IW'(item_slot);
  assign rd_en     = cmd.rd_issue | cmd.walk_read;
  assign rd_addr   = cmd.rd_issue ? slot_addr : idx;

  assign eff_count  = rd_vld ? rd_count : '0;
  assign eff_period = rd_vld ? rd_period : '0;
  assign active     = (eff_count != '0);
  assign dec_count  = eff_count - COUNT_WIDTH'(1);
  assign expire     = active && (dec_count == '0) && rd_vld && rd_event;
  assign report     = expire && (rep_cnt < REP_W'(MAX_REPORTS));
  assign out_free   = !out_valid || out_ready;
  assign upd_push   = cmd.walk_upd && report && hold_valid;
  assign count_ext  = 32'(eff_count);
  assign period_ext = 32'(eff_period);

  assign stat.out_free   = out_free;
  assign stat.upd_stall  = report && hold_valid && !out_free;
  assign stat.idx_last   = (idx == IW'(NUM_SLOTS - 1));
  assign stat.hold_valid = hold_valid;

  // Single write port: loads, or the walk's update of an active slot.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = idx;
    wr_count  = dec_count;
    wr_period = rd_period;
    wr_event  = rd_event;
    if (cmd.load_wr) begin
      wr_en     = slot_ok;
      wr_addr   = slot_addr;
      wr_count  = item_delay;
      wr_period = item_period;
      wr_event  = item_event;
    end else if (cmd.walk_upd && active) begin
      wr_en    = 1'b1;
      wr_count = expire ? eff_period : dec_count;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      count_mem[wr_addr]  <= wr_count;
      period_mem[wr_addr] <= wr_period;
      event_mem[wr_addr]  <= wr_event;
    end
    if (rd_en) begin
      rd_count  <= count_mem[rd_addr];
      rd_period <= period_mem[rd_addr];
      rd_event  <= event_mem[rd_addr];
      rd_vld    <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_slot   <= in_slot;
      item_delay  <= COUNT_WIDTH'(in_delay);
      item_period <= COUNT_WIDTH'(in_period);
      item_event  <= in_event;
    end
  end

  // Walk index, report count and expiry hold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      rep_cnt    <= '0;
      hold_valid <= 1'b0;
    end else if (cmd.capture) begin
      idx        <= '0;
      rep_cnt    <= '0;
      hold_valid <= 1'b0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (cmd.walk_upd && report) begin
        rep_cnt    <= rep_cnt + REP_W'(1);
        hold_valid <= 1'b1;
      end else if (cmd.flush_push) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_upd && report) begin
      hold_slot <= SLOT_W'(idx);
      hold_rem  <= period_ext[FIELD_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rd_push || upd_push || cmd.flush_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_push) begin
      out_kind <= KIND_READ;
      out_slot <= item_slot;
      out_rem  <= slot_ok ? count_ext[FIELD_W-1:0] : '0;
      out_last <= 1'b1;
    end else if (upd_push || cmd.flush_push) begin
      out_kind <= KIND_EXPIRY;
      out_slot <= hold_slot;
      out_rem  <= hold_rem;
      out_last <= cmd.flush_push;
    end
  end

endmodule : ctb_dpath
`default_nettype wire

// ===== rtl/countdown_timer_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Countdown timer bank
// A bank of millisecond countdown slots with reload and expiry reporting.
// ----------------------------------------------------------------------------
// Each input item is a tick, a load or a read, selected by s_axis_tuser. A
// load writes one slot's delay, reload period and event flag and gives no
// result. A read gives one result with the slot's remaining count (zero for
// a slot beyond the bank). A tick walks the slots in ascending order with one
// shared decrementer: every nonzero slot counts down, and an event slot that
// reaches zero reloads its period and reports an expiry; a period of zero
// makes it one-shot. At most sixteen expiries are reported per tick, the
// final one marked by m_axis_tlast, and a tick with none gives no result.
// A tick reads each slot from the slot store and then writes it back, and
// holding m_axis_tready low while a result waits stalls a read or a tick.
// The block takes one item at a time, but a finished result may sit in the
// output register while the next item is accepted. All slots read as zero
// straight after reset.
// ----------------------------------------------------------------------------
module countdown_timer_bank #(
  parameter int NUM_SLOTS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  // Input items.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] slot, [19:4] load_delay, [35:20] load_period, [36] raises_event,
  // [39:37] zero.
  input  wire  [39:0] s_axis_tdata,
  // [1:0] mode.
  input  wire  [1:0]  s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [3:0] which_slot, [19:4] remaining, [23:20] zero.
  output logic [23:0] m_axis_tdata,
  // [0] kind.
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import ctb_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic               out_kind;
  logic [SLOT_W-1:0]  out_slot;
  logic [FIELD_W-1:0] out_rem;

  ctb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_mode  (s_axis_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  ctb_dpath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_slot   (s_axis_tdata[3:0]),
    .in_delay  (s_axis_tdata[19:4]),
    .in_period (s_axis_tdata[35:20]),
    .in_event  (s_axis_tdata[36]),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (out_kind),
    .out_slot  (out_slot),
    .out_rem   (out_rem),
    .out_last  (m_axis_tlast)
  );

  // Unused upper bits of the input data are ignored.
  assign m_axis_tdata    = {4'b0000, out_rem, out_slot};
  assign m_axis_tuser[0] = out_kind;

endmodule : countdown_timer_bank
`default_nettype wire

// ===== bench/tb_countdown_timer_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank testbench
// Drives tick, load and read items into the timer bank and checks every
// result against a slot-by-slot prediction, under random stalls on both sides.
// ----------------------------------------------------------------------------
// A short directed run covers the read straight after reset, an unused mode,
// a tick that expires nothing, all sixteen slots expiring in one tick, a
// one-shot slot, a plain slot stopping at zero and an inactive load. Random
// traffic follows, mostly short delays so that slots really do run out, in
// phases with gaps on both sides, with no gaps at all, and with the result
// side held off for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_countdown_timer_bank;
  import ctb_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int BANK_SLOTS   = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int LIMIT_CYCLES = 1500000;

  // The one mode value that the block ignores.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] remaining;
    logic               last;
  } timer_result_t;

  // Keeps its own copy of the slot stores and the queue of results still owed.
  class timer_scoreboard;
    logic [FIELD_W-1:0] slot_count[BANK_SLOTS];
    logic [FIELD_W-1:0] slot_period[BANK_SLOTS];
    logic               slot_event[BANK_SLOTS];
    timer_result_t      owed_results[$];
    int                 failures;

    function new();
      for (int i = 0; i < BANK_SLOTS; i++) begin
        slot_count[i]  = '0;
        slot_period[i] = '0;
        slot_event[i]  = 1'b0;
      end
      failures = 0;
    endfunction

    function void note_item(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                            logic [FIELD_W-1:0] delay, logic [FIELD_W-1:0] period,
                            logic raises_event);
      timer_result_t res;
      int            reported;
      reported = 0;
      case (mode)
        MODE_TICK: begin
          for (int i = 0; i < BANK_SLOTS; i++) begin
            if (slot_count[i] != '0) begin
              slot_count[i] = slot_count[i] - FIELD_W'(1);
              if (slot_count[i] == '0 && slot_event[i]) begin
                slot_count[i] = slot_period[i];
                if (reported < MAX_REPORTS) begin
                  res.kind      = KIND_EXPIRY;
                  res.slot      = SLOT_W'(i);
                  res.remaining = slot_count[i];
                  res.last      = 1'b0;
                  owed_results.push_back(res);
                  reported++;
                end
              end
            end
          end
          if (reported > 0) owed_results[owed_results.size()-1].last = 1'b1;
        end
        MODE_LOAD: begin
          slot_count[slot]  = delay;
          slot_period[slot] = period;
          slot_event[slot]  = raises_event;
        end
        MODE_READ: begin
          res.kind      = KIND_READ;
          res.slot      = slot;
          res.remaining = slot_count[slot];
          res.last      = 1'b1;
          owed_results.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic kind, logic [SLOT_W-1:0] slot,
                               logic [FIELD_W-1:0] remaining, logic last);
      timer_result_t want;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: kind %0d slot %0d remaining %0d last %0d",
               kind, slot, remaining, last);
        failures++;
        return;
      end
      want = owed_results.pop_front();
      if (kind !== want.kind) begin
        $error("kind mismatch: expected %0d, got %0d", want.kind, kind);
        failures++;
      end
      if (slot !== want.slot) begin
        $error("which_slot mismatch: expected %0d, got %0d", want.slot, slot);
        failures++;
      end
      if (remaining !== want.remaining) begin
        $error("remaining mismatch: expected %0d, got %0d", want.remaining, remaining);
        failures++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0d, got %0d", want.last, last);
        failures++;
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Stall controls shared between the stimulus and the result side.
  logic tx_gappy;
  logic rx_gappy;
  logic hold_off_req;
  int   cycle_count;

  timer_scoreboard board;

  countdown_timer_bank uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short pauses, now and then a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(2, 1);
    if (pick < 95) return $urandom_range(8, 3);
    return $urandom_range(60, 20);
  endfunction

  // Both handshakes are sampled here at the edge, before any of this edge's
  // updates land. A result seen at the same edge as a new item always belongs
  // to an earlier item, so the order of the two calls does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tuser[0], m_axis_tdata[3:0], m_axis_tdata[19:4],
                           m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        board.note_item(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[19:4],
                        s_axis_tdata[35:20], s_axis_tdata[36]);
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_countdown_timer_bank failed");
      $finish;
    end
  end

  // Result side. Each pass of the loop ends on a clock edge, so tready gets at
  // most one update per edge. A long hold-off is counted out here on request.
  initial begin
    m_axis_tready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_gappy && $urandom_range(99) < 25) begin
        m_axis_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high from one item to the next unless a gap is inserted first.
  task automatic offer_item(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                            input logic [FIELD_W-1:0] delay,
                            input logic [FIELD_W-1:0] period, input logic raises_event);
    int gap;
    gap = 0;
    if (tx_gappy && $urandom_range(99) < 35) gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {3'b000, raises_event, period, delay, slot};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Random item. Loads mostly use short delays and periods so that slots
  // actually expire; a few take full-range values to exercise every bit.
  task automatic offer_random_item(input int read_pct);
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] delay;
    logic [FIELD_W-1:0] period;
    int                 pick;
    pick   = $urandom_range(99);
    delay  = FIELD_W'($urandom);
    period = FIELD_W'($urandom);
    if (pick < read_pct)
      mode = MODE_READ;
    else if (pick < read_pct + (100 - read_pct) / 2)
      mode = MODE_TICK;
    else if (pick < 95)
      mode = MODE_LOAD;
    else
      mode = MODE_UNUSED;
    if (mode == MODE_LOAD) begin
      pick = $urandom_range(99);
      if (pick < 85)
        delay = FIELD_W'($urandom_range(12, 1));
      else if (pick < 90)
        delay = '0;
      pick = $urandom_range(99);
      if (pick < 40)
        period = '0;
      else if (pick < 85)
        period = FIELD_W'($urandom_range(10, 1));
    end
    offer_item(mode, SLOT_W'($urandom_range(BANK_SLOTS - 1)), delay, period,
               $urandom_range(99) < 70);
  endtask

  initial begin
    board         = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_TICK;
    tx_gappy      = 1'b0;
    rx_gappy      = 1'b0;
    hold_off_req  = 1'b0;
    cycle_count   = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: read of a cleared slot, an ignored mode, an empty tick.
    offer_item(MODE_READ, 4'd0, 16'h0000, 16'h0000, 1'b0);
    offer_item(MODE_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1);
    offer_item(MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0);

    // Every slot an event slot about to run out: one tick gives sixteen
    // expiries. Slot 0 is one-shot, slot 1 reloads every tick and slot 15
    // reloads the largest period.
    for (int i = 0; i < BANK_SLOTS; i++) begin
      if (i == 0)
        offer_item(MODE_LOAD, SLOT_W'(i), 16'd1, 16'd0, 1'b1);
      else if (i == 1)
        offer_item(MODE_LOAD, SLOT_W'(i), 16'd1, 16'd1, 1'b1);
      else if (i == BANK_SLOTS - 1)
        offer_item(MODE_LOAD, SLOT_W'(i), 16'd1, 16'hFFFF, 1'b1);
      else
        offer_item(MODE_LOAD, SLOT_W'(i), 16'd1, FIELD_W'($urandom_range(5, 1)), 1'b1);
    end
    offer_item(MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0);
    offer_item(MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0);
    offer_item(MODE_READ, 4'd0, 16'h0000, 16'h0000, 1'b0);
    offer_item(MODE_READ, 4'd15, 16'h0000, 16'h0000, 1'b0);

    // A plain slot counts down to zero silently and stays there.
    offer_item(MODE_LOAD, 4'd4, 16'd1, 16'hFFFF, 1'b0);
    offer_item(MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0);
    offer_item(MODE_READ, 4'd4, 16'h0000, 16'h0000, 1'b0);

    // A zero delay leaves the slot inactive even with a period set.
    offer_item(MODE_LOAD, 4'd9, 16'd0, 16'd7, 1'b1);
    offer_item(MODE_READ, 4'd9, 16'h0000, 16'h0000, 1'b0);

    // Random traffic with gaps on both sides.
    tx_gappy = 1'b1;
    rx_gappy = 1'b1;
    for (int n = 0; n < 150; n++) offer_random_item(20);

    // Back-to-back traffic with no idling on either side.
    tx_gappy = 1'b0;
    rx_gappy = 1'b0;
    for (int n = 0; n < 80; n++) offer_random_item(20);

    // The result side stops for a long stretch while reads keep coming, so
    // the output register fills and the block stops taking items.
    hold_off_req = 1'b1;
    for (int n = 0; n < 50; n++) offer_random_item(60);

    tx_gappy = 1'b1;
    rx_gappy = 1'b1;
    for (int n = 0; n < 80; n++) offer_random_item(20);
    s_axis_tvalid <= 1'b0;

    // Wait for every owed result, then allow a last tick walk to settle.
    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.failures == 0)
      $display("tb_countdown_timer_bank passed");
    else
      $display("tb_countdown_timer_bank failed");
    $finish;
  end

endmodule
